// File: hw/rtl/cau_pkg.sv
// Shared request codes for the complex arithmetic unit.
package cau_pkg;

	// request type carried with each transaction
	typedef logic [2:0] req_t;

	localparam req_t REQ_MUL  = 3'd0;
	localparam req_t REQ_DIV  = 3'd1;
	localparam req_t REQ_MAG  = 3'd2;
	localparam req_t REQ_SQRT = 3'd3;
	localparam req_t REQ_CONJ = 3'd4;

endpackage

// File: hw/rtl/cau_div_cell.sv
// One restoring-division cell: two lanes share a divisor, one quotient bit per lane.
module cau_div_cell #(
	parameter int RW = 64,
	parameter int QW = 32
) (
	input  logic                 clk,
	input  logic [1:0][RW-1:0]   rem_i,
	input  logic [1:0][QW-1:0]   num_i,
	input  logic [1:0][QW-1:0]   quo_i,
	input  logic [RW-1:0]        den_i,
	output logic [1:0][RW-1:0]   rem_o,
	output logic [1:0][QW-1:0]   num_o,
	output logic [1:0][QW-1:0]   quo_o,
	output logic [RW-1:0]        den_o
);

	logic [1:0][RW:0]   trial;
	logic [1:0][RW:0]   diff;
	logic [1:0][RW-1:0] rem_n;
	logic [1:0]         ge;

	// shift in the next numerator bit, subtract the divisor where it fits
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			trial[l] = {rem_i[l], num_i[l][QW-1]};
			diff[l]  = trial[l] - {1'b0, den_i};
			ge[l]    = (trial[l] >= {1'b0, den_i});
			rem_n[l] = ge[l] ? diff[l][RW-1:0] : trial[l][RW-1:0];
		end
	end

	// hand the partial remainder and quotient to the next cell
	always_ff @(posedge clk) begin
		for (int l = 0; l < 2; l++) begin
			rem_o[l] <= rem_n[l];
			num_o[l] <= {num_i[l][QW-2:0], 1'b0};
			quo_o[l] <= {quo_i[l][QW-2:0], ge[l]};
		end
		den_o <= den_i;
	end

endmodule

// File: hw/rtl/cau_sqrt_cell.sv
// One digit-by-digit square root cell: consumes two radicand bits, yields one root bit per lane.
module cau_sqrt_cell #(
	parameter int RW    = 64,
	parameter int LANES = 1
) (
	input  logic                        clk,
	input  logic [LANES-1:0][RW-1:0]    rad_i,
	input  logic [LANES-1:0][RW/2+1:0]  rem_i,
	input  logic [LANES-1:0][RW/2-1:0]  root_i,
	output logic [LANES-1:0][RW-1:0]    rad_o,
	output logic [LANES-1:0][RW/2+1:0]  rem_o,
	output logic [LANES-1:0][RW/2-1:0]  root_o
);

	localparam int H = RW / 2;

	logic [LANES-1:0][H+3:0] cur;
	logic [LANES-1:0][H+3:0] trial;
	logic [LANES-1:0][H+3:0] rem_n;
	logic [LANES-1:0]        ge;

	// bring down the next bit pair and try root*4+1
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			cur[l]   = {rem_i[l], rad_i[l][RW-1 -: 2]};
			trial[l] = {2'b00, root_i[l], 2'b01};
			ge[l]    = (cur[l] >= trial[l]);
			rem_n[l] = ge[l] ? (cur[l] - trial[l]) : cur[l];
		end
	end

	// advance radicand, remainder and root to the next cell
	always_ff @(posedge clk) begin
		for (int l = 0; l < LANES; l++) begin
			rad_o[l]  <= {rad_i[l][RW-3:0], 2'b00};
			rem_o[l]  <= rem_n[l][H+1:0];
			root_o[l] <= {root_i[l][H-2:0], ge[l]};
		end
	end

endmodule

// File: hw/rtl/complex_arith_unit_top.sv
// Top level of the complex multiply, divide, magnitude, square root and conjugate unit.
//
//  channel   direction  handshake                 payload
//  request   in         start && !busy            req_type, a_re, a_im, b_re, b_im
//  result    out        res_valid (one cycle)     res_re, res_im, div_zero, saturated
//
// One transaction is taken every cycle; busy stays low.
// A result passes the operand, product, sum and chain-entry registers, then the division
// and magnitude cell chains (DATA_WIDTH cells), a register, the square root cell chain
// ((DATA_WIDTH+FRAC_BITS+1)/2 cells) and the output register.
// Reset clears the valid line only; datapath registers carry no reset.
// The receiver cannot stall: each result shows for exactly one cycle.
module complex_arith_unit_top #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  cau_pkg::req_t                 req_type,
	input  logic signed [DATA_WIDTH-1:0]  a_re,
	input  logic signed [DATA_WIDTH-1:0]  a_im,
	input  logic signed [DATA_WIDTH-1:0]  b_re,
	input  logic signed [DATA_WIDTH-1:0]  b_im,
	output logic                          res_valid,
	output logic signed [DATA_WIDTH-1:0]  res_re,
	output logic signed [DATA_WIDTH-1:0]  res_im,
	output logic                          div_zero,
	output logic                          saturated
);

	import cau_pkg::*;

	localparam int W   = DATA_WIDTH;
	localparam int F   = FRAC_BITS;
	localparam int XW  = 2 * W + F + 4;
	localparam int CW  = 3 * W + F;
	localparam int PW  = W + F + 2;
	localparam int SW  = W + F + ((W + F) % 2);
	localparam int K   = SW / 2;
	localparam int LAT = W + K + 6;

	localparam logic signed [XW-1:0]   ONE  = XW'(1);
	localparam logic signed [XW-1:0]   MAXV = (ONE <<< (W - 1)) - ONE;
	localparam logic signed [XW-1:0]   MINV = -(ONE <<< (W - 1));
	localparam logic [W-1:0]           MAXW = MAXV[W-1:0];
	localparam logic [W-1:0]           MINW = MINV[W-1:0];
	localparam logic signed [2*W+1:0]  BIAS = (2 * W + 2)'((1 << F) - 1);

	typedef struct packed {
		logic [W-1:0] val;
		logic         sat;
	} sat_res_t;

	typedef struct packed {
		req_t         req;
		logic         b_neg;
		logic         dz;
		logic         sat;
		logic [W-1:0] re;
		logic [W-1:0] im;
		logic [W-1:0] a;
		logic         neg_re;
		logic         neg_im;
		logic         ovf_re;
		logic         ovf_im;
	} meta_t;

	// clamp a wide signed value to the result range
	function automatic sat_res_t sat_clamp(input logic signed [XW-1:0] v);
		sat_res_t r;
		if (v > MAXV) begin
			r.val = MAXW;
			r.sat = 1'b1;
		end else if (v < MINV) begin
			r.val = MINW;
			r.sat = 1'b1;
		end else begin
			r.val = v[W-1:0];
			r.sat = 1'b0;
		end
		return r;
	endfunction

	// apply sign and range to a quotient magnitude
	function automatic sat_res_t div_clamp(input logic [W-1:0] q, input logic neg,
		input logic ovf);
		sat_res_t         r;
		logic signed [XW-1:0] v;
		v = XW'(q);
		if (neg) begin
			v = -v;
		end
		if (ovf) begin
			r.val = neg ? MINW : MAXW;
			r.sat = 1'b1;
		end else begin
			r = sat_clamp(v);
		end
		return r;
	endfunction

	// shift right by the fraction width, truncating toward zero
	function automatic logic signed [2*W+1:0] trunc_shift(input logic signed [2*W:0] v);
		logic signed [2*W+1:0] e;
		e = (2 * W + 2)'(v);
		if (v < 0) begin
			e = e + BIAS;
		end
		return e >>> F;
	endfunction

	assign busy = 1'b0;

	// ---------------- valid line ----------------
	logic        v_s1, v_s2, v_s3;
	logic [W:0]  vc_q;
	logic [K:0]  vs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			vc_q      <= '0;
			vs_q      <= '0;
			res_valid <= 1'b0;
		end else begin
			v_s1      <= start;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			vc_q      <= {vc_q[W-1:0], v_s3};
			vs_q      <= {vs_q[K-1:0], vc_q[W]};
			res_valid <= vs_q[K];
		end
	end

	// ---------------- stage 1: capture operands ----------------
	req_t                req_s1;
	logic signed [W-1:0] are_s1, aim_s1, bre_s1, bim_s1;

	always_ff @(posedge clk) begin
		req_s1 <= req_type;
		are_s1 <= a_re;
		aim_s1 <= a_im;
		bre_s1 <= b_re;
		bim_s1 <= b_im;
	end

	// ---------------- stage 2: products ----------------
	req_t                  req_s2;
	logic signed [W-1:0]   are_s2, aim_s2;
	logic signed [2*W-1:0] p_ac_s2, p_bd_s2, p_ad_s2, p_bc_s2, p_xx_s2, p_yy_s2;
	logic signed [W-1:0]   sq_x, sq_y;

	// squares feed the divisor for divide, the magnitude otherwise
	assign sq_x = (req_s1 == REQ_DIV) ? bre_s1 : are_s1;
	assign sq_y = (req_s1 == REQ_DIV) ? bim_s1 : aim_s1;

	always_ff @(posedge clk) begin
		req_s2  <= req_s1;
		are_s2  <= are_s1;
		aim_s2  <= aim_s1;
		p_ac_s2 <= are_s1 * bre_s1;
		p_bd_s2 <= aim_s1 * bim_s1;
		p_ad_s2 <= are_s1 * bim_s1;
		p_bc_s2 <= aim_s1 * bre_s1;
		p_xx_s2 <= sq_x * sq_x;
		p_yy_s2 <= sq_y * sq_y;
	end

	// ---------------- stage 3: sums ----------------
	req_t                  req_s3;
	logic signed [W-1:0]   are_s3, aim_s3;
	logic signed [2*W:0]   sum_re_s3, sum_im_s3;
	logic [2*W-1:0]        sq_s3;

	always_ff @(posedge clk) begin
		req_s3 <= req_s2;
		are_s3 <= are_s2;
		aim_s3 <= aim_s2;
		if (req_s2 == REQ_MUL) begin
			sum_re_s3 <= p_ac_s2 - p_bd_s2;
			sum_im_s3 <= p_ad_s2 + p_bc_s2;
		end else begin
			sum_re_s3 <= p_ac_s2 + p_bd_s2;
			sum_im_s3 <= p_bc_s2 - p_ad_s2;
		end
		sq_s3 <= $unsigned(p_xx_s2) + $unsigned(p_yy_s2);
	end

	// ---------------- stage 4: chain entry ----------------
	meta_t                 meta_n4;
	logic [1:0][2*W-1:0]   drem_n4;
	logic [1:0][W-1:0]     dnum_n4;
	logic [2*W-1:0]        mag_re, mag_im;
	logic [CW-1:0]         num_re_w, num_im_w, den_w, hi_re_w, hi_im_w;
	sat_res_t              mr, mi, ci;

	always_comb begin
		mr = sat_clamp(XW'(trunc_shift(sum_re_s3)));
		mi = sat_clamp(XW'(trunc_shift(sum_im_s3)));
		ci = sat_clamp(-XW'(aim_s3));

		// numerator magnitudes scaled up by the fraction width
		mag_re   = (sum_re_s3 < 0) ? (2 * W)'(-sum_re_s3) : (2 * W)'(sum_re_s3);
		mag_im   = (sum_im_s3 < 0) ? (2 * W)'(-sum_im_s3) : (2 * W)'(sum_im_s3);
		num_re_w = CW'(mag_re) << F;
		num_im_w = CW'(mag_im) << F;
		den_w    = CW'(sq_s3) << W;
		hi_re_w  = num_re_w >> W;
		hi_im_w  = num_im_w >> W;
		drem_n4[0] = hi_re_w[2*W-1:0];
		drem_n4[1] = hi_im_w[2*W-1:0];
		dnum_n4[0] = num_re_w[W-1:0];
		dnum_n4[1] = num_im_w[W-1:0];

		meta_n4        = '0;
		meta_n4.req    = req_s3;
		meta_n4.b_neg  = aim_s3[W-1];
		meta_n4.a      = are_s3;
		meta_n4.neg_re = (sum_re_s3 < 0);
		meta_n4.neg_im = (sum_im_s3 < 0);
		meta_n4.ovf_re = (num_re_w >= den_w);
		meta_n4.ovf_im = (num_im_w >= den_w);
		meta_n4.dz     = (req_s3 == REQ_DIV) && (sq_s3 == '0);
		case (req_s3)
			REQ_MUL: begin
				meta_n4.re  = mr.val;
				meta_n4.im  = mi.val;
				meta_n4.sat = mr.sat | mi.sat;
			end
			REQ_CONJ: begin
				meta_n4.re  = are_s3;
				meta_n4.im  = ci.val;
				meta_n4.sat = ci.sat;
			end
			default: begin
				meta_n4.sat = 1'b0;
			end
		endcase
	end

	logic [1:0][2*W-1:0] drem_s4;
	logic [1:0][W-1:0]   dnum_s4;
	logic [2*W-1:0]      dden_s4;
	logic [2*W-1:0]      mrad_s4;
	meta_t               meta1_q [0:W];

	always_ff @(posedge clk) begin
		drem_s4    <= drem_n4;
		dnum_s4    <= dnum_n4;
		dden_s4    <= sq_s3;
		mrad_s4    <= sq_s3;
		meta1_q[0] <= meta_n4;
		for (int i = 1; i <= W; i++) begin
			meta1_q[i] <= meta1_q[i-1];
		end
	end

	// ---------------- division and magnitude cell chains ----------------
	logic [1:0][2*W-1:0] drem  [0:W];
	logic [1:0][W-1:0]   dnum  [0:W];
	logic [1:0][W-1:0]   dquo  [0:W];
	logic [2*W-1:0]      dden  [0:W];
	logic [0:0][2*W-1:0] mrad  [0:W];
	logic [0:0][W+1:0]   mrem  [0:W];
	logic [0:0][W-1:0]   mroot [0:W];

	assign drem[0]  = drem_s4;
	assign dnum[0]  = dnum_s4;
	assign dquo[0]  = '0;
	assign dden[0]  = dden_s4;
	assign mrad[0]  = mrad_s4;
	assign mrem[0]  = '0;
	assign mroot[0] = '0;

	for (genvar i = 0; i < W; i++) begin : g_chain1
		cau_div_cell #(.RW(2 * W), .QW(W)) u_div (
			.clk   (clk),
			.rem_i (drem[i]),
			.num_i (dnum[i]),
			.quo_i (dquo[i]),
			.den_i (dden[i]),
			.rem_o (drem[i+1]),
			.num_o (dnum[i+1]),
			.quo_o (dquo[i+1]),
			.den_o (dden[i+1])
		);

		cau_sqrt_cell #(.RW(2 * W), .LANES(1)) u_mag (
			.clk    (clk),
			.rad_i  (mrad[i]),
			.rem_i  (mrem[i]),
			.root_i (mroot[i]),
			.rad_o  (mrad[i+1]),
			.rem_o  (mrem[i+1]),
			.root_o (mroot[i+1])
		);
	end

	// ---------------- stage 5: finish divide and magnitude, form root radicands ----------------
	meta_t                 meta_n5;
	logic [1:0][SW-1:0]    srad_n5;
	logic [W-1:0]          mag_m;
	logic signed [W+1:0]   mx, ax, sp, sn;
	logic [PW-1:0]         pp, pn;
	sat_res_t              dr, di, mm;

	always_comb begin
		mag_m = mroot[W][0];
		dr = div_clamp(dquo[W][0], meta1_q[W].neg_re, meta1_q[W].ovf_re);
		di = div_clamp(dquo[W][1], meta1_q[W].neg_im, meta1_q[W].ovf_im);
		mm = sat_clamp(XW'(mag_m));

		// (M + a) and (M - a), scaled and halved
		mx = {2'b00, mag_m};
		ax = (W + 2)'($signed(meta1_q[W].a));
		sp = mx + ax;
		sn = mx - ax;
		pp = (PW'($unsigned(sp)) << F) >> 1;
		pn = (PW'($unsigned(sn)) << F) >> 1;
		srad_n5[0] = pp[SW-1:0];
		srad_n5[1] = pn[SW-1:0];

		meta_n5 = meta1_q[W];
		case (meta1_q[W].req)
			REQ_DIV: begin
				if (meta1_q[W].dz) begin
					meta_n5.re  = '0;
					meta_n5.im  = '0;
					meta_n5.sat = 1'b0;
				end else begin
					meta_n5.re  = dr.val;
					meta_n5.im  = di.val;
					meta_n5.sat = dr.sat | di.sat;
				end
			end
			REQ_MAG: begin
				meta_n5.re  = mm.val;
				meta_n5.im  = '0;
				meta_n5.sat = mm.sat;
			end
			default: begin
				meta_n5.sat = meta1_q[W].sat;
			end
		endcase
	end

	logic [1:0][SW-1:0] srad_s5;
	meta_t              meta2_q [0:K];

	always_ff @(posedge clk) begin
		srad_s5    <= srad_n5;
		meta2_q[0] <= meta_n5;
		for (int i = 1; i <= K; i++) begin
			meta2_q[i] <= meta2_q[i-1];
		end
	end

	// ---------------- square root cell chain ----------------
	logic [1:0][SW-1:0]   srad  [0:K];
	logic [1:0][K+1:0]    srem  [0:K];
	logic [1:0][K-1:0]    sroot [0:K];

	assign srad[0]  = srad_s5;
	assign srem[0]  = '0;
	assign sroot[0] = '0;

	for (genvar i = 0; i < K; i++) begin : g_chain2
		cau_sqrt_cell #(.RW(SW), .LANES(2)) u_root (
			.clk    (clk),
			.rad_i  (srad[i]),
			.rem_i  (srem[i]),
			.root_i (sroot[i]),
			.rad_o  (srad[i+1]),
			.rem_o  (srem[i+1]),
			.root_o (sroot[i+1])
		);
	end

	// ---------------- output stage ----------------
	logic signed [XW-1:0] t_im;
	sat_res_t             qr, qi;

	always_comb begin
		t_im = XW'(sroot[K][1]);
		if (meta2_q[K].b_neg) begin
			t_im = -t_im;
		end
		qr = sat_clamp(XW'(sroot[K][0]));
		qi = sat_clamp(t_im);
	end

	always_ff @(posedge clk) begin
		div_zero <= meta2_q[K].dz;
		if (meta2_q[K].req == REQ_SQRT) begin
			res_re    <= qr.val;
			res_im    <= qi.val;
			saturated <= qr.sat | qi.sat;
		end else begin
			res_re    <= meta2_q[K].re;
			res_im    <= meta2_q[K].im;
			saturated <= meta2_q[K].sat;
		end
	end

	// ---------------- assertions ----------------
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT res_valid)
		else $error("accepted transaction produced no result at the fixed latency");

	a_div_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && div_zero) |-> (!saturated && res_re == '0 && res_im == '0))
		else $error("zero divisor result is not a clean zero");

	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && saturated) |-> (res_re == MAXW || res_re == MINW ||
			res_im == MAXW || res_im == MINW))
		else $error("saturation flagged without a clamped part");

endmodule
